[design/glpf_pkg.sv]
// Shared constants, types and helper functions for the grid local peak finder.
`default_nettype none

package glpf_pkg;

  localparam int MAX_COLS   = 32;
  localparam int MAX_ROWS   = 64;
  localparam int NUM_LINES  = 3;
  localparam int SAMPLE_W   = 16;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COLS_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROWS_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int BUF_W      = $clog2(NUM_LINES);
  localparam int MEM_DEPTH  = NUM_LINES * MAX_COLS;
  // Line address is {line, column}; MAX_COLS is a power of two.
  localparam int MEM_AW     = BUF_W + COL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROWS_CNT_W;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_MID,
    ST_RD_UP,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_RD_WAIT,
    ST_DECIDE,
    ST_FINISH
  } seq_state_t;

  typedef enum logic {
    MODE_UPPER,
    MODE_FLUSH
  } check_mode_t;

  typedef struct packed {
    logic                       we;
    logic [MEM_AW-1:0]          waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic [MEM_AW-1:0]          raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } peak_push_t;

  function automatic logic [ROWS_CNT_W-1:0] clamp_rows(input logic [ROWS_CNT_W-1:0] v);
    logic [ROWS_CNT_W-1:0] res;
    res = v;
    if (v < ROWS_CNT_W'(2)) res = ROWS_CNT_W'(2);
    else if (v > ROWS_CNT_W'(MAX_ROWS)) res = ROWS_CNT_W'(MAX_ROWS);
    return res;
  endfunction

  function automatic logic [COLS_CNT_W-1:0] clamp_cols(input logic [COLS_CNT_W-1:0] v);
    logic [COLS_CNT_W-1:0] res;
    res = v;
    if (v < COLS_CNT_W'(2)) res = COLS_CNT_W'(2);
    else if (v > COLS_CNT_W'(MAX_COLS)) res = COLS_CNT_W'(MAX_COLS);
    return res;
  endfunction

  // Rotate to the following line buffer, modulo three.
  function automatic logic [BUF_W-1:0] line_after(input logic [BUF_W-1:0] b);
    logic [BUF_W-1:0] res;
    res = (b == BUF_W'(NUM_LINES - 1)) ? BUF_W'(0) : b + BUF_W'(1);
    return res;
  endfunction

  // Previous line buffer, modulo three.
  function automatic logic [BUF_W-1:0] line_before(input logic [BUF_W-1:0] b);
    logic [BUF_W-1:0] res;
    res = (b == BUF_W'(0)) ? BUF_W'(NUM_LINES - 1) : b - BUF_W'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

[design/glpf_line_mem.sv]
// Three-line sample store: one write port, one registered read port.
`default_nettype none

module glpf_line_mem (
  input  wire logic                                clk,
  input  wire glpf_pkg::mem_req_t                  req,
  output logic signed [glpf_pkg::SAMPLE_W-1:0]     rdata
);

  logic signed [glpf_pkg::SAMPLE_W-1:0] mem [glpf_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

[design/glpf_seq.sv]
// Sequencer: frame position, line rotation, neighbor reads and peak decisions.
`default_nettype none

module glpf_seq (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   restart,
  input  wire logic [glpf_pkg::ROWS_CNT_W-1:0]        rows,
  input  wire logic [glpf_pkg::COLS_CNT_W-1:0]        cols,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [glpf_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                                   out_free,
  output glpf_pkg::peak_push_t                        push,
  output glpf_pkg::mem_req_t                          mem_req,
  input  wire logic signed [glpf_pkg::SAMPLE_W-1:0]   mem_rdata
);

  glpf_pkg::seq_state_t  state, state_next;
  glpf_pkg::check_mode_t mode;

  logic [glpf_pkg::ROW_W-1:0] pos_r;
  logic [glpf_pkg::COL_W-1:0] pos_c;
  logic [glpf_pkg::BUF_W-1:0] rot;

  logic                       wrap;
  logic [glpf_pkg::ROW_W-1:0] r_eff;
  logic [glpf_pkg::COL_W-1:0] c_eff;
  logic [glpf_pkg::BUF_W-1:0] cur_eff;
  logic                       final_eff;
  logic                       row_end_eff;
  logic                       in_fire;

  logic [glpf_pkg::ROW_W-1:0] item_r;
  logic [glpf_pkg::BUF_W-1:0] item_cur;
  logic                       item_final;
  logic [glpf_pkg::COL_W-1:0] col;

  logic signed [glpf_pkg::SAMPLE_W-1:0] down_val, mid_val, up_val, left_val, right_val;

  logic [glpf_pkg::BUF_W-1:0] mid_buf, up_buf;
  logic                       has_up, has_down, has_left, has_right;
  logic [glpf_pkg::ROW_W-1:0] chk_row;
  logic                       peak;
  logic                       stall;

  logic                       pend_valid;
  logic [glpf_pkg::ROW_W-1:0] pend_row;
  logic [glpf_pkg::COL_W-1:0] pend_col;

  // Position of the incoming sample, restarting the frame if it fell outside the grid.
  always_comb begin
    wrap        = ({1'b0, pos_r} >= rows) || ({1'b0, pos_c} >= cols);
    r_eff       = wrap ? '0 : pos_r;
    c_eff       = wrap ? '0 : pos_c;
    cur_eff     = wrap ? '0 : rot;
    row_end_eff = ({1'b0, c_eff} == cols - glpf_pkg::COLS_CNT_W'(1));
    final_eff   = row_end_eff && ({1'b0, r_eff} == rows - glpf_pkg::ROWS_CNT_W'(1));
    in_fire     = in_valid && in_ready;
  end

  // Neighborhood of the cell under test.
  always_comb begin
    if (mode == glpf_pkg::MODE_FLUSH) begin
      mid_buf  = item_cur;
      up_buf   = glpf_pkg::line_before(item_cur);
      has_up   = 1'b1;
      has_down = 1'b0;
      chk_row  = item_r;
    end else begin
      mid_buf  = glpf_pkg::line_before(item_cur);
      up_buf   = glpf_pkg::line_after(item_cur);
      has_up   = (item_r >= glpf_pkg::ROW_W'(2));
      has_down = 1'b1;
      chk_row  = item_r - glpf_pkg::ROW_W'(1);
    end
    has_left  = (col != '0);
    has_right = ({1'b0, col} != cols - glpf_pkg::COLS_CNT_W'(1));
    peak = !(has_up    && (mid_val < up_val))
        && !(has_down  && (mid_val < down_val))
        && !(has_left  && (mid_val < left_val))
        && !(has_right && (mid_val < right_val));
    stall = peak && pend_valid && !out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      glpf_pkg::ST_IDLE: begin
        if (in_fire && !restart && (r_eff != '0)) state_next = glpf_pkg::ST_RD_MID;
      end
      glpf_pkg::ST_RD_MID:   state_next = glpf_pkg::ST_RD_UP;
      glpf_pkg::ST_RD_UP:    state_next = glpf_pkg::ST_RD_LEFT;
      glpf_pkg::ST_RD_LEFT:  state_next = glpf_pkg::ST_RD_RIGHT;
      glpf_pkg::ST_RD_RIGHT: state_next = glpf_pkg::ST_RD_WAIT;
      glpf_pkg::ST_RD_WAIT:  state_next = glpf_pkg::ST_DECIDE;
      glpf_pkg::ST_DECIDE: begin
        if (!stall) begin
          if (mode == glpf_pkg::MODE_UPPER && item_final) state_next = glpf_pkg::ST_RD_MID;
          else if (mode == glpf_pkg::MODE_FLUSH && has_right) state_next = glpf_pkg::ST_RD_MID;
          else state_next = glpf_pkg::ST_FINISH;
        end
      end
      glpf_pkg::ST_FINISH: begin
        if (!pend_valid || out_free) state_next = glpf_pkg::ST_IDLE;
      end
      default: state_next = glpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == glpf_pkg::ST_IDLE);
    mem_req.we    = in_fire;
    mem_req.waddr = {cur_eff, c_eff};
    mem_req.wdata = in_sample;
    case (state)
      glpf_pkg::ST_RD_UP:    mem_req.raddr = {up_buf, col};
      glpf_pkg::ST_RD_LEFT:  mem_req.raddr = {mid_buf, col - glpf_pkg::COL_W'(1)};
      glpf_pkg::ST_RD_RIGHT: mem_req.raddr = {mid_buf, col + glpf_pkg::COL_W'(1)};
      default:               mem_req.raddr = {mid_buf, col};
    endcase
    push.valid = 1'b0;
    push.row   = pend_row;
    push.col   = pend_col;
    push.last  = 1'b0;
    case (state)
      glpf_pkg::ST_DECIDE: push.valid = peak && pend_valid && out_free;
      glpf_pkg::ST_FINISH: begin
        push.valid = pend_valid && out_free;
        push.last  = 1'b1;
      end
      default: push.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= glpf_pkg::ST_IDLE;
      pos_r      <= '0;
      pos_c      <= '0;
      rot        <= '0;
      pend_valid <= 1'b0;
      mode       <= glpf_pkg::MODE_UPPER;
    end else begin
      state <= state_next;
      if (restart) begin
        pos_r <= '0;
        pos_c <= '0;
        rot   <= '0;
      end else if (in_fire) begin
        if (final_eff) begin
          pos_r <= '0;
          pos_c <= '0;
          rot   <= '0;
        end else if (row_end_eff) begin
          pos_r <= r_eff + glpf_pkg::ROW_W'(1);
          pos_c <= '0;
          rot   <= glpf_pkg::line_after(cur_eff);
        end else begin
          pos_r <= r_eff;
          pos_c <= c_eff + glpf_pkg::COL_W'(1);
          rot   <= cur_eff;
        end
      end
      if (in_fire) begin
        mode <= glpf_pkg::MODE_UPPER;
      end else if (state == glpf_pkg::ST_DECIDE && !stall && item_final) begin
        mode <= glpf_pkg::MODE_FLUSH;
      end
      if (state == glpf_pkg::ST_DECIDE && !stall && peak) begin
        pend_valid <= 1'b1;
      end else if (state == glpf_pkg::ST_FINISH && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r     <= r_eff;
      item_cur   <= cur_eff;
      item_final <= final_eff;
      down_val   <= in_sample;
      col        <= c_eff;
    end else if (state == glpf_pkg::ST_DECIDE && !stall) begin
      // advance to the next bottom-row cell; the first flush cell is column zero
      if (mode == glpf_pkg::MODE_UPPER) col <= '0;
      else col <= col + glpf_pkg::COL_W'(1);
    end
    case (state)
      glpf_pkg::ST_RD_UP:    mid_val   <= mem_rdata;
      glpf_pkg::ST_RD_LEFT:  up_val    <= mem_rdata;
      glpf_pkg::ST_RD_RIGHT: left_val  <= mem_rdata;
      glpf_pkg::ST_RD_WAIT:  right_val <= mem_rdata;
      default: ;
    endcase
    if (state == glpf_pkg::ST_DECIDE && !stall && peak) begin
      pend_row <= chk_row;
      pend_col <= col;
    end
  end

endmodule

`default_nettype wire

[design/grid_local_peak_finder_unit.sv]
// Top level of the grid local peak finder: config registers, output register, core.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata[15:0] sample
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata[5:0] peak_row, [10:6] peak_col,
//            |           |                             | tlast last_of_run
//  cfg       | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// A sample of the first grid row is only written to the line store. For any later sample,
// the cell above it is decided from four reads through the single read port of the
// line store (center, up, left, right), one per cycle, then a wait, a decide and a drain step.
// The frame's final sample then repeats the reads and the decide for each bottom-row column.
// Reset clears position, line rotation and size (2 by 2); the line store is not cleared.
// A stalled output holds the sequencer when a second peak is ready to be queued, and
// at the drain step while the item's final peak waits for the output register.
`default_nettype none

module grid_local_peak_finder_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample request, tdata: [15:0] sample
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [glpf_pkg::SAMPLE_W-1:0]       s_axis_tdata,
  // peak request, tdata: [5:0] peak_row, [10:6] peak_col, [15:11] zero
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [glpf_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  output logic                                     m_axis_tlast,
  // configuration write request
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [glpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [glpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [glpf_pkg::ROWS_CNT_W-1:0] grid_rows;
  logic [glpf_pkg::COLS_CNT_W-1:0] grid_cols;
  logic                            cfg_fire;
  logic                            restart;
  logic                            out_free;

  glpf_pkg::peak_push_t            push;
  glpf_pkg::mem_req_t              mem_req;
  logic signed [glpf_pkg::SAMPLE_W-1:0] mem_rdata;

  logic [glpf_pkg::ROW_W-1:0]      out_row;
  logic [glpf_pkg::COL_W-1:0]      out_col;

  // Configuration is always taken; a write to a known register restarts the frame.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire &&
                     ((cfg_index == glpf_pkg::REG_GRID_ROWS) ||
                      (cfg_index == glpf_pkg::REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= glpf_pkg::ROWS_CNT_W'(2);
      grid_cols <= glpf_pkg::COLS_CNT_W'(2);
    end else if (cfg_fire) begin
      case (cfg_index)
        glpf_pkg::REG_GRID_ROWS: grid_rows <= cfg_data;
        glpf_pkg::REG_GRID_COLS: grid_cols <= cfg_data[glpf_pkg::COLS_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  glpf_line_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  glpf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .rows      (glpf_pkg::clamp_rows(grid_rows)),
    .cols      (glpf_pkg::clamp_cols(grid_cols)),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .out_free  (out_free),
    .push      (push),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_row      <= push.row;
      out_col      <= push.col;
      m_axis_tlast <= push.last;
    end
  end

  assign m_axis_tdata = glpf_pkg::OUT_DATA_W'({out_col, out_row});

endmodule

`default_nettype wire

[design/glpf_checker.sv]
// Port-level checks of the grid local peak finder, bound to the top level.
`default_nettype none

module glpf_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [glpf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic                              m_axis_tlast
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Pad bits above the column field stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[glpf_pkg::OUT_DATA_W-1:glpf_pkg::ROW_W+glpf_pkg::COL_W]
                       == '0))
    else $error("nonzero pad bits on output");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind grid_local_peak_finder_unit glpf_checker u_glpf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the grid local peak finder: streamed frames, scoreboard, stalls.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF_NS   = 5;
  localparam int RESET_CYCLES  = 12;
  // Worst internal work with no result: the final sample's checks plus the bottom-row flush.
  localparam int SETTLE_CYCLES = 260;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 32;
  localparam int MAX_REPORTS   = 10;
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  // Register indexes with no register behind them.
  localparam logic [glpf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = glpf_pkg::CFG_IDX_W'(2);
  localparam logic [glpf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = glpf_pkg::CFG_IDX_W'(3);

  // Sample value flavors.
  localparam int VAL_FULL    = 0;
  localparam int VAL_NARROW  = 1;
  localparam int VAL_FLAT    = 2;
  localparam int VAL_EXTREME = 3;

  // Receiver stall flavors.
  localparam int RX_ALWAYS = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;

  typedef struct {
    logic [glpf_pkg::ROW_W-1:0] row;
    logic [glpf_pkg::COL_W-1:0] col;
    logic                       last;
  } peak_rec_t;

  logic clk = 1'b0;
  logic rst;

  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [glpf_pkg::SAMPLE_W-1:0]   s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [glpf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [glpf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [glpf_pkg::CFG_DATA_W-1:0] cfg_data;

  grid_local_peak_finder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Peak predictor: its own copy of the line buffers, size registers and position.
  // ---------------------------------------------------------------------------
  logic signed [glpf_pkg::SAMPLE_W-1:0] line_copy [glpf_pkg::NUM_LINES][glpf_pkg::MAX_COLS];
  logic [6:0] rows_reg = 7'd2;
  logic [5:0] cols_reg = 6'd2;
  int pos_row = 0;
  int pos_col = 0;
  int rot     = 0;

  peak_rec_t pending_peaks[$];
  int err_cnt = 0;

  // Sender and receiver control shared between processes (one writer each).
  int burst_left   = 0;
  bit tx_no_gaps   = 1'b0;
  int hold_req_cnt = 0;

  function automatic int size_clamp(input int v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // A cell is a peak when no existing 4-neighbour is larger.
  function automatic bit is_peak(input int up_b, input bit has_up, input int mid_b,
                                 input int dn_b, input bit has_dn, input int col,
                                 input int cols);
    logic signed [glpf_pkg::SAMPLE_W-1:0] ctr;
    ctr = line_copy[mid_b][col];
    if (has_up && ctr < line_copy[up_b][col]) return 1'b0;
    if (has_dn && ctr < line_copy[dn_b][col]) return 1'b0;
    if (col > 0 && ctr < line_copy[mid_b][col-1]) return 1'b0;
    if (col + 1 < cols && ctr < line_copy[mid_b][col+1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_peak(input int r, input int c);
    peak_rec_t pk;
    pk.row  = glpf_pkg::ROW_W'(r);
    pk.col  = glpf_pkg::COL_W'(c);
    pk.last = 1'b0;
    pending_peaks.push_back(pk);
  endfunction

  function automatic void apply_config(input logic [glpf_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [glpf_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      glpf_pkg::REG_GRID_ROWS: rows_reg = val;
      glpf_pkg::REG_GRID_COLS: cols_reg = val[5:0];
      default: return;
    endcase
    // Any size write restarts the frame at cell (0,0).
    pos_row = 0;
    pos_col = 0;
    rot     = 0;
  endfunction

  function automatic void predict_peaks(input logic signed [glpf_pkg::SAMPLE_W-1:0] v);
    int rows, cols, r, c, cur, prev, old, first_new;
    rows = size_clamp(int'(rows_reg), glpf_pkg::MAX_ROWS);
    cols = size_clamp(int'(cols_reg), glpf_pkg::MAX_COLS);
    r = pos_row;
    c = pos_col;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
      rot = 0;
    end
    cur  = rot % 3;
    prev = (cur + 2) % 3;
    old  = (cur + 1) % 3;
    first_new = pending_peaks.size();
    line_copy[cur][c] = v;
    // The cell above the new sample now has all its neighbours.
    if (r >= 1 && is_peak(old, r >= 2, prev, cur, 1'b1, c, cols)) push_peak(r - 1, c);
    if (r == rows - 1 && c == cols - 1) begin
      // Final sample: flush the whole bottom row.
      for (int k = 0; k < cols; k++) begin
        if (is_peak(prev, 1'b1, cur, cur, 1'b0, k, cols)) push_peak(r, k);
      end
      pos_row = 0;
      pos_col = 0;
      rot     = 0;
    end else begin
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
        rot = (cur + 1) % 3;
      end
      pos_row = r;
      pos_col = c;
    end
    if (pending_peaks.size() > first_new)
      pending_peaks[pending_peaks.size()-1].last = 1'b1;
  endfunction

  function automatic void log_failure(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Peak checker: compare every accepted peak request with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    peak_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_peaks.size() == 0) begin
        log_failure($sformatf("unexpected peak row %0d col %0d last %0b",
                              m_axis_tdata[5:0], m_axis_tdata[10:6], m_axis_tlast));
      end else begin
        want = pending_peaks.pop_front();
        if (m_axis_tdata[5:0] !== want.row || m_axis_tdata[10:6] !== want.col ||
            m_axis_tdata[15:11] !== 5'd0 || m_axis_tlast !== want.last)
          log_failure($sformatf("peak expected row %0d col %0d last %0b, got tdata %h last %b",
                                want.row, want.col, want.last, m_axis_tdata, m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own; serve long hold-offs on request.
  // ---------------------------------------------------------------------------
  initial begin : rx_pattern
    int mode, mode_left, hold_left, hold_served;
    mode = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    hold_served = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_req_cnt) begin
        hold_served = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(RX_HEAVY, RX_ALWAYS);
          mode_left = $urandom_range(80, 8);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_LIGHT:  m_axis_tready <= ($urandom_range(3) != 0);
          default:   m_axis_tready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Send one sample request in bursts with random gaps; predict once accepted.
  task automatic send_sample(input logic signed [glpf_pkg::SAMPLE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_no_gaps || $urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= glpf_pkg::SAMPLE_W'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    predict_peaks(v);
  endtask

  // Drop valid, drain every predicted peak, then let the block finish internal work.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [glpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [glpf_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [glpf_pkg::SAMPLE_W-1:0] pick_sample(input int vmode,
      input logic signed [glpf_pkg::SAMPLE_W-1:0] flat_v);
    case (vmode)
      VAL_FULL:   return glpf_pkg::SAMPLE_W'($urandom);
      VAL_NARROW: return glpf_pkg::SAMPLE_W'($signed($urandom_range(6)) - 3);
      VAL_FLAT:   return flat_v;
      default: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_value_mode();
    int roll;
    roll = $urandom_range(19);
    if (roll < 10) return VAL_NARROW;
    if (roll < 15) return VAL_FULL;
    if (roll < 17) return VAL_FLAT;
    return VAL_EXTREME;
  endfunction

  task automatic send_frame(input int count, input int vmode);
    logic signed [glpf_pkg::SAMPLE_W-1:0] flat_v;
    flat_v = glpf_pkg::SAMPLE_W'($urandom);
    repeat (count) send_sample(pick_sample(vmode, flat_v));
  endtask

  task automatic set_size(input int rows_raw, input int cols_raw);
    write_reg(glpf_pkg::REG_GRID_ROWS, glpf_pkg::CFG_DATA_W'(rows_raw));
    write_reg(glpf_pkg::REG_GRID_COLS, glpf_pkg::CFG_DATA_W'(cols_raw));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset size (2 by 2): plateau, value extremes, back-to-back frames.
  task automatic test_default_size();
    send_sample(16'sd7);
    send_sample(16'sd7);
    send_sample(16'sd7);
    send_sample(16'sd7);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
  endtask

  // Out-of-range sizes saturate; the column register keeps only six bits.
  task automatic test_size_clamp();
    set_size(0, 1);
    send_frame(4, VAL_NARROW);
    set_size(127, 63);
    send_frame(4, VAL_NARROW);
    set_size(1, 64);
    send_frame(4, VAL_EXTREME);
    set_size(65, 33);
    send_frame(36, VAL_FULL);
    set_size(2, 2);
    send_frame(4, VAL_NARROW);
  endtask

  // Unknown indexes leave the frame running; a size write restarts it.
  task automatic test_restart();
    set_size(3, 5);
    send_frame(7, VAL_NARROW);
    write_reg(REG_SPARE_2, 7'h7f);
    send_frame(8, VAL_NARROW);
    write_reg(REG_SPARE_3, 7'h00);
    send_frame(4, VAL_NARROW);
    write_reg(glpf_pkg::REG_GRID_COLS, 7'd5);
    send_frame(15, VAL_NARROW);
  endtask

  // Widest and tallest grids; a flat 2 by 32 frame yields the longest run.
  task automatic test_size_extremes();
    set_size(2, 32);
    send_frame(64, VAL_FLAT);
    set_size(64, 2);
    send_frame(128, VAL_NARROW);
  endtask

  // Hold off the receiver while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    set_size(4, 4);
    tx_no_gaps = 1'b1;
    hold_req_cnt++;
    send_frame(16, VAL_FLAT);
    tx_no_gaps = 1'b0;
  endtask

  // Random sizes (mostly small) and frames, some cut short by the next size write.
  task automatic test_random_frames();
    int sent, rows_raw, cols_raw, cells, count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      rows_raw = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(8, 2);
      cols_raw = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(8, 2);
      cells = size_clamp(rows_raw, glpf_pkg::MAX_ROWS) *
              size_clamp(cols_raw % 64, glpf_pkg::MAX_COLS);
      if (cells > 160) begin
        rows_raw = $urandom_range(4, 2);
        cells = rows_raw * size_clamp(cols_raw % 64, glpf_pkg::MAX_COLS);
      end
      set_size(rows_raw, cols_raw);
      repeat ($urandom_range(3, 1)) begin
        count = ($urandom_range(5) == 0) ? $urandom_range(cells - 1, 1) : cells;
        if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
        if (count > 0) begin
          send_frame(count, pick_value_mode());
          sent += count;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int b = 0; b < glpf_pkg::NUM_LINES; b++)
      for (int k = 0; k < glpf_pkg::MAX_COLS; k++) line_copy[b][k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_size();
    test_size_clamp();
    test_restart();
    test_size_extremes();
    test_backpressure();
    test_random_frames();

    wait_idle();
    if (err_cnt == 0 && pending_peaks.size() == 0) begin
      $display("grid_local_peak_finder_unit verification clean");
    end else begin
      $display("grid_local_peak_finder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("grid_local_peak_finder_unit verification failed");
    $finish;
  end

endmodule
